/* rtl/lzsd_pkg.sv */
// Shared types, constants and defaults for the LZSS stream decompressor.
package lzsd_pkg;

   localparam int WINDOW_BITS_DEF    = 12;
   localparam int LENGTH_BITS_DEF    = 4;
   localparam int MIN_MATCH_BIAS_DEF = 2;
   localparam int HEADER_BYTES_DEF   = 8;

   // flag index value meaning "next byte is a flag byte"
   localparam logic [3:0] FLAG_DONE = 4'd8;
   localparam int SIZE_BYTES = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_start;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       size_reached;
   } rsp_item_type;

   // parser -> copy engine control
   typedef struct packed {
      logic launch;
      logic literal;
      logic restart;
   } cmd_type;

   typedef enum logic [0:0] {
      CP_IDLE,
      CP_COPY
   } cp_state_type;

endpackage

/* rtl/lzsd_ring.sv */
// History ring with registered read, write-to-read bypass and fill-count masking.
module lzsd_ring #(
   parameter int WINDOW_BITS = lzsd_pkg::WINDOW_BITS_DEF
) (
   input  logic                   clock,
   input  logic [WINDOW_BITS-1:0] rd_addr,
   input  logic                   wr_en,
   input  logic [WINDOW_BITS-1:0] wr_addr,
   input  logic [7:0]             wr_data,
   input  logic [WINDOW_BITS-1:0] fill_count,
   input  logic                   fill_wrap,
   output logic [7:0]             rd_data
);

   localparam int DEPTH = 2 ** WINDOW_BITS;

   logic [7:0] ring_mem [DEPTH];
   logic [7:0] rd_q_ff;
   logic       byp_hit_ff;
   logic [7:0] byp_data_ff;
   logic       live_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      rd_q_ff     <= ring_mem[rd_addr];
      byp_hit_ff  <= wr_en && (wr_addr == rd_addr);
      byp_data_ff <= wr_data;
      // entries at or above the fill count were not written since restart
      live_ff     <= fill_wrap || (rd_addr < fill_count);
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : (live_ff ? rd_q_ff : 8'h00);

endmodule

/* rtl/lzsd_copy.sv */
// Copy engine: emits literal and match bytes one per cycle, while the output is not stalled, through the ring.
module lzsd_copy #(
   parameter int WINDOW_BITS = lzsd_pkg::WINDOW_BITS_DEF,
   parameter int LEN_W       = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lzsd_pkg::cmd_type      cmd,
   input  logic [7:0]             cmd_lit,
   input  logic [WINDOW_BITS-1:0] cmd_pos,
   input  logic [LEN_W-1:0]       cmd_len,
   input  logic [31:0]            declared_size,
   output logic                   busy,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lzsd_pkg::rsp_item_type rsp_data
);

   lzsd_pkg::cp_state_type state_ff, state_in;
   logic [WINDOW_BITS-1:0] src_ff, src_in;
   logic [LEN_W-1:0]       remain_ff, remain_in;
   logic [7:0]             lit_ff, lit_in;
   logic                   is_lit_ff, is_lit_in;
   logic [31:0]            count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   lzsd_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic        at_limit;
   logic        slot_free;
   logic        emit;
   logic        last_byte;
   logic [31:0] count_plus;
   logic [7:0]  ring_data;
   logic [7:0]  cur_byte;

   assign count_plus = count_ff + 32'd1;
   assign at_limit   = (count_ff == declared_size);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign last_byte  = (remain_ff == LEN_W'(1)) || (count_plus == declared_size);
   assign cur_byte   = is_lit_ff ? lit_ff : ring_data;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lzsd_pkg::CP_IDLE: begin
            if (cmd.launch) state_in = lzsd_pkg::CP_COPY;
         end
         lzsd_pkg::CP_COPY: begin
            if (at_limit || (emit && last_byte)) state_in = lzsd_pkg::CP_IDLE;
         end
         default: state_in = lzsd_pkg::CP_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      emit = 1'b0;
      busy = 1'b0;
      unique case (state_ff)
         lzsd_pkg::CP_IDLE: begin
            busy = 1'b0;
         end
         lzsd_pkg::CP_COPY: begin
            busy = 1'b1;
            emit = !at_limit && slot_free;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_comb begin
      src_in    = src_ff;
      remain_in = remain_ff;
      lit_in    = lit_ff;
      is_lit_in = is_lit_ff;
      count_in  = count_ff;
      if (state_ff == lzsd_pkg::CP_IDLE) begin
         if (cmd.restart) count_in = '0;
         if (cmd.launch) begin
            src_in    = cmd_pos;
            remain_in = cmd.literal ? LEN_W'(1) : cmd_len;
            lit_in    = cmd_lit;
            is_lit_in = cmd.literal;
         end
      end
      if (emit) begin
         src_in    = src_ff + WINDOW_BITS'(1);
         remain_in = remain_ff - LEN_W'(1);
         count_in  = count_plus;
      end
   end

   always_comb begin
      rsp_data_in              = rsp_data_ff;
      rsp_data_in.out_byte     = cur_byte;
      rsp_data_in.run_last     = last_byte;
      rsp_data_in.size_reached = (count_plus == declared_size);
      if (!emit) rsp_data_in = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzsd_pkg::CP_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff      <= src_in;
      remain_ff   <= remain_in;
      lit_ff      <= lit_in;
      is_lit_ff   <= is_lit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // read address follows the next source pointer so data lines up with COPY
   lzsd_ring #(
      .WINDOW_BITS(WINDOW_BITS)
   ) u_ring (
      .clock      (clock),
      .rd_addr    (src_in),
      .wr_en      (emit),
      .wr_addr    (count_ff[WINDOW_BITS-1:0]),
      .wr_data    (cur_byte),
      .fill_count (count_ff[WINDOW_BITS-1:0]),
      .fill_wrap  (count_ff[31:WINDOW_BITS] != '0),
      .rd_data    (ring_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_copy_remain: assert property (@(posedge clock) disable iff (reset)
      state_ff == lzsd_pkg::CP_COPY |-> remain_ff != '0)
      else $error("copy active with nothing left");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      emit |=> count_ff == $past(count_ff) + 32'd1)
      else $error("output count not advanced by one");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && last_byte) |=> state_ff == lzsd_pkg::CP_IDLE)
      else $error("copy continued past last byte");

endmodule

/* rtl/lzss_stream_decompressor_unit.sv */
// Top level of the LZSS stream decompressor: header and token parser plus copy engine.
//
// Usage: compressed bytes enter on the req_ channel (req_valid / req_stall /
// req_data), one byte per transaction. req_data.stream_start marks the first
// header byte of a stream and restarts the decoder. The first four of the
// header bytes give the output size (little endian); then flag bytes
// (LSB first, 1 = literal, 0 = two-byte match token) drive the decode.
// Decoded bytes leave on the rsp_ channel, one per transaction, with run_last
// on the final byte caused by an input transaction and size_reached when the
// declared size is met. Bytes past the declared size are dropped.
// Header, flag and match-low bytes do not start the copy engine. A literal or a
// match (3 to 18 bytes) starts it; it reads one ring entry a cycle while rsp_stall
// is low, and ends without output when every byte would be dropped.
// Results pass through the copy engine's output register to rsp_.
// req_stall is high while the copy engine runs. When the receiver holds
// rsp_stall, the output register keeps its transaction and the copy engine
// waits; the last result may sit there while the next request is taken.
// Reset (synchronous, active high) puts the decoder in the expect-header
// state. The ring is never swept: a fill count hides entries not yet written
// since the last restart, which read as zero, so no clearing pass is needed.
module lzss_stream_decompressor_unit #(
   parameter int WINDOW_BITS    = lzsd_pkg::WINDOW_BITS_DEF,
   parameter int LENGTH_BITS    = lzsd_pkg::LENGTH_BITS_DEF,
   parameter int MIN_MATCH_BIAS = lzsd_pkg::MIN_MATCH_BIAS_DEF,
   parameter int HEADER_BYTES   = lzsd_pkg::HEADER_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lzsd_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lzsd_pkg::rsp_item_type rsp_data
);

   localparam int LEN_W  = $clog2(2 ** LENGTH_BITS + MIN_MATCH_BIAS + 1);
   localparam int HIDX_W = $clog2(HEADER_BYTES + 1);

   // parser state
   logic [HIDX_W-1:0] hidx_ff, hidx_in;
   logic [31:0]       decl_ff, decl_in;
   logic [7:0]        flags_ff, flags_in;
   logic [3:0]        fidx_ff, fidx_in;
   logic [7:0]        low_ff, low_in;
   logic              await_ff, await_in;

   // values after an optional restart by this transaction
   logic [HIDX_W-1:0] eff_hidx;
   logic [31:0]       eff_decl;
   logic [7:0]        eff_flags;
   logic [3:0]        eff_fidx;
   logic              eff_await;

   logic                   accept;
   logic                   busy;
   logic [7:0]             b;
   lzsd_pkg::cmd_type      cmd;
   logic [31:0]            pos_sum;
   logic [WINDOW_BITS-1:0] cmd_pos;
   logic [LEN_W-1:0]       cmd_len;

   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;
   assign b         = req_data.in_byte;

   // match token decode: high byte carries length (low bits) and position (high bits)
   assign pos_sum = (((32'(b) >> LENGTH_BITS) << 8) | 32'(low_ff))
                    + 32'(2 ** LENGTH_BITS + MIN_MATCH_BIAS);
   assign cmd_pos = pos_sum[WINDOW_BITS-1:0];
   assign cmd_len = LEN_W'(b[LENGTH_BITS-1:0]) + LEN_W'(MIN_MATCH_BIAS + 1);

   always_comb begin
      eff_hidx  = req_data.stream_start ? '0 : hidx_ff;
      eff_decl  = req_data.stream_start ? '0 : decl_ff;
      eff_flags = req_data.stream_start ? '0 : flags_ff;
      eff_fidx  = req_data.stream_start ? lzsd_pkg::FLAG_DONE : fidx_ff;
      eff_await = req_data.stream_start ? 1'b0 : await_ff;

      hidx_in  = hidx_ff;
      decl_in  = decl_ff;
      flags_in = flags_ff;
      fidx_in  = fidx_ff;
      low_in   = low_ff;
      await_in = await_ff;
      cmd      = '0;

      if (accept) begin
         hidx_in     = eff_hidx;
         decl_in     = eff_decl;
         flags_in    = eff_flags;
         fidx_in     = eff_fidx;
         await_in    = eff_await;
         cmd.restart = req_data.stream_start;
         if (eff_hidx < HIDX_W'(HEADER_BYTES)) begin
            // size bytes are merged little endian; the rest of the header is skipped
            if (eff_hidx < HIDX_W'(lzsd_pkg::SIZE_BYTES)) begin
               decl_in = eff_decl | (32'(b) << {eff_hidx[1:0], 3'b000});
            end
            hidx_in = eff_hidx + HIDX_W'(1);
         end else if (eff_await) begin
            await_in   = 1'b0;
            fidx_in    = eff_fidx + 4'd1;
            cmd.launch = 1'b1;
         end else if (eff_fidx >= lzsd_pkg::FLAG_DONE) begin
            flags_in = b;
            fidx_in  = '0;
         end else if (eff_flags[eff_fidx[2:0]]) begin
            fidx_in     = eff_fidx + 4'd1;
            cmd.launch  = 1'b1;
            cmd.literal = 1'b1;
         end else begin
            low_in   = b;
            await_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hidx_ff  <= '0;
         decl_ff  <= '0;
         flags_ff <= '0;
         fidx_ff  <= lzsd_pkg::FLAG_DONE;
         await_ff <= 1'b0;
      end else begin
         hidx_ff  <= hidx_in;
         decl_ff  <= decl_in;
         flags_ff <= flags_in;
         fidx_ff  <= fidx_in;
         await_ff <= await_in;
      end
      low_ff <= low_in;
   end

   lzsd_copy #(
      .WINDOW_BITS (WINDOW_BITS),
      .LEN_W       (LEN_W)
   ) u_copy (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cmd_lit       (b),
      .cmd_pos       (cmd_pos),
      .cmd_len       (cmd_len),
      .declared_size (decl_ff),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

   a_await_in_group: assert property (@(posedge clock) disable iff (reset)
      await_ff |-> fidx_ff < lzsd_pkg::FLAG_DONE)
      else $error("match pending outside a flag group");

   a_header_no_launch: assert property (@(posedge clock) disable iff (reset)
      (accept && eff_hidx < HIDX_W'(HEADER_BYTES)) |-> !cmd.launch)
      else $error("copy launched during header");

   a_launch_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.launch |=> busy)
      else $error("copy engine did not start");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the LZSS stream decompressor: random streams, scoreboard, stalls.
module testbench;

   // Decoder geometry, taken from the package defaults the unit is built with.
   localparam int WIN_BITS     = lzsd_pkg::WINDOW_BITS_DEF;
   localparam int WIN_SIZE     = 1 << WIN_BITS;
   localparam int LEN_BITS     = lzsd_pkg::LENGTH_BITS_DEF;
   localparam int LEN_MASK     = (1 << LEN_BITS) - 1;
   localparam int MIN_BIAS     = lzsd_pkg::MIN_MATCH_BIAS_DEF;
   localparam int HDR_BYTES    = lzsd_pkg::HEADER_BYTES_DEF;
   // offset the compressor subtracts from a match position before encoding it
   localparam int POS_BIAS     = (1 << LEN_BITS) + MIN_BIAS;
   localparam int RANDOM_ITEMS = 220;
   // longest match plus output register, with margin
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD    = 300;

   // Scoreboard: mirrors the decoder state and keeps the decoded bytes that the
   // unit still owes, oldest first.
   class lzss_decode_scoreboard;
      logic [7:0]   window [0:WIN_SIZE-1];
      logic [31:0]  produced;
      logic [31:0]  declared;
      int unsigned  header_pos;
      logic [7:0]   flags;
      logic [3:0]   flag_pos;
      logic [7:0]   low_byte;
      bit           high_pending;
      lzsd_pkg::rsp_item_type burst [$];
      lzsd_pkg::rsp_item_type decoded_q [$];
      int unsigned  failures;

      function new();
         failures = 0;
         restart();
      endfunction

      function void restart();
         foreach (window[i]) window[i] = 8'h00;
         produced     = '0;
         declared     = '0;
         header_pos   = 0;
         flags        = '0;
         flag_pos     = lzsd_pkg::FLAG_DONE;
         low_byte     = '0;
         high_pending = 1'b0;
      endfunction

      // one output byte; bytes past the declared size vanish without a trace
      function void emit(logic [7:0] value);
         lzsd_pkg::rsp_item_type r;
         if (produced == declared) return;
         window[produced[WIN_BITS-1:0]] = value;
         produced++;
         r.out_byte     = value;
         r.run_last     = 1'b0;
         r.size_reached = (produced == declared);
         burst.push_back(r);
      endfunction

      function void note_compressed_byte(lzsd_pkg::req_item_type item);
         logic [7:0]  b;
         int unsigned len;
         int unsigned base;
         b = item.in_byte;
         burst.delete();
         if (item.stream_start) restart();
         if (header_pos < HDR_BYTES) begin
            if (header_pos < lzsd_pkg::SIZE_BYTES) declared[8*header_pos +: 8] = b;
            header_pos++;
            return;
         end
         if (high_pending) begin
            len  = (b & LEN_MASK) + MIN_BIAS + 1;
            base = (((b >> LEN_BITS) << 8) | low_byte) + POS_BIAS;
            high_pending = 1'b0;
            flag_pos++;
            // byte by byte, so an overlapping copy sees its own output
            for (int i = 0; i < len; i++) emit(window[WIN_BITS'(base + i)]);
         end else if (flag_pos >= lzsd_pkg::FLAG_DONE) begin
            flags    = b;
            flag_pos = '0;
         end else if (flags[flag_pos]) begin
            flag_pos++;
            emit(b);
         end else begin
            low_byte     = b;
            high_pending = 1'b1;
         end
         if (burst.size() > 0) burst[$].run_last = 1'b1;
         foreach (burst[i]) decoded_q.push_back(burst[i]);
      endfunction

      function void check_decoded_byte(lzsd_pkg::rsp_item_type got);
         lzsd_pkg::rsp_item_type want;
         if (decoded_q.size() == 0) begin
            $error("unexpected decoded byte %02h", got.out_byte);
            failures++;
            return;
         end
         want = decoded_q.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
            failures++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
            failures++;
         end
         if (got.size_reached !== want.size_reached) begin
            $error("size_reached: expected %0b, got %0b", want.size_reached, got.size_reached);
            failures++;
         end
      endfunction

      function int pending();
         return decoded_q.size();
      endfunction
   endclass

   logic         clock         = 1'b0;
   logic         reset         = 1'b1;
   logic         req_valid     = 1'b0;
   logic         req_stall;
   lzsd_pkg::req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall     = 1'b0;
   lzsd_pkg::rsp_item_type rsp_data;

   // knobs shared by the driver and the receiver
   bit           req_gaps_on   = 1'b1;
   logic         rsp_stalls_on = 1'b1;
   logic         long_hold_req = 1'b0;

   lzss_decode_scoreboard sb;
   int unsigned  payload_count;
   // generator's own idea of how many bytes the stream has produced so far,
   // used to aim match positions at recent output
   int unsigned  gen_out;

   always #5 clock = ~clock;

   lzss_stream_decompressor_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Transaction monitor. Inputs are driven with nonblocking assignments, so at
   // the edge this sees the values the unit sampled.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_compressed_byte(req_data);
         if (rsp_valid && !rsp_stall) sb.check_decoded_byte(rsp_data);
      end
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one compressed byte and hold it until the unit takes it. Returns at
   // the edge where the transaction was accepted.
   task automatic send_byte(input logic [7:0] value, input logic start = 1'b0);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_data.in_byte      <= value;
      req_data.stream_start <= start;
      do @(posedge clock); while (req_stall);
      payload_count++;
   endtask

   // Size bytes (little endian) then the filler bytes the decoder skips.
   task automatic send_header(input logic [31:0] decl, input logic [31:0] filler,
                              input logic start);
      send_byte(decl[7:0], start);
      send_byte(decl[15:8]);
      send_byte(decl[23:16]);
      send_byte(decl[31:24]);
      send_byte(filler[7:0]);
      send_byte(filler[15:8]);
      send_byte(filler[23:16]);
      send_byte(filler[31:24]);
   endtask

   // Match token aimed mostly a short distance back (overlapping copies, and
   // reads of the cleared ring early in a stream), sometimes anywhere.
   task automatic send_match();
      int unsigned target;
      int unsigned raw;
      int unsigned len_field;
      if ($urandom_range(0, 9) < 7)
         target = (gen_out + WIN_SIZE * 8 - $urandom_range(1, 24)) % WIN_SIZE;
      else
         target = $urandom_range(0, WIN_SIZE - 1);
      len_field = $urandom_range(0, LEN_MASK);
      raw = (target + WIN_SIZE - POS_BIAS) % WIN_SIZE;
      send_byte(raw[7:0]);
      send_byte(8'(((raw >> 8) << LEN_BITS) | len_field));
      gen_out += len_field + MIN_BIAS + 1;
   endtask

   // One stream: header, then a few flag groups of literals and matches.
   // Some streams are cut short (possibly mid-token), a few carry stray bytes,
   // and a few lack the start mark, so their header bytes decode as tokens.
   task automatic send_random_stream(input bit force_empty);
      logic [31:0] decl;
      logic [7:0]  flag;
      int          sel;
      int          groups;
      bit          start;
      bit          cut;
      sel = $urandom_range(0, 9);
      if (force_empty || sel == 0) decl = '0;
      else if (sel == 1) decl = $urandom();
      else if (sel == 2) decl = $urandom_range(1, 8);
      else decl = $urandom_range(20, 150);
      start = force_empty || ($urandom_range(0, 9) != 0);
      req_gaps_on   = ($urandom_range(0, 3) != 0);
      rsp_stalls_on <= ($urandom_range(0, 3) != 0);
      send_header(decl, $urandom(), start);
      if (start) gen_out = 0;
      cut    = ($urandom_range(0, 4) == 0);
      groups = $urandom_range(1, 4);
      for (int g = 0; g < groups; g++) begin
         flag = 8'($urandom_range(0, 255));
         send_byte(flag);
         for (int k = 0; k < 8; k++) begin
            if (payload_count >= RANDOM_ITEMS) return;
            if (cut && $urandom_range(0, 9) == 0) begin
               // truncated: maybe leave a match low byte waiting
               if (!flag[k]) send_byte(8'($urandom_range(0, 255)));
               return;
            end
            if ($urandom_range(0, 29) == 0) begin
               send_byte(8'($urandom_range(0, 255)));
            end else if (flag[k]) begin
               send_byte(8'($urandom_range(0, 255)));
               gen_out++;
            end else begin
               send_match();
            end
         end
      end
   endtask

   // Receiver: random stalls, stall-free stretches, and on request one long
   // hold-off so the unit backs up and stalls its input.
   initial begin
      int hold;
      int r;
      hold = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req <= 1'b0;
            hold = LONG_HOLD;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (!rsp_stalls_on) begin
            rsp_stall <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_stall <= 1'b0;
            end else if (r < 92) begin
               hold = $urandom_range(0, 2);
               rsp_stall <= 1'b1;
            end else begin
               hold = $urandom_range(8, 30);
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   // Stimulus and end of test.
   initial begin
      int stream_idx;
      sb = new();
      payload_count = 0;
      gen_out = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed. First stream has no start mark: reset already expects the
      // header. Size 3, filler bytes all-ones/zeros.
      send_header(32'd3, 32'h00FF00FF, 1'b0);
      send_byte(8'h02);            // flags: match, literal, match, ...
      send_byte(8'h00);            // longest match into the cleared ring:
      send_byte(8'h0F);            //   3 zero bytes, the other 15 dropped
      send_byte(8'hFF);            // literal past the size: no transaction
      send_byte(8'h55);            // match low byte left pending...
      // ...and thrown away by a restart; maximum declared size
      send_header(32'hFFFFFFFF, 32'h00000000, 1'b1);
      send_byte(8'hFD);            // literal, match, then literals
      send_byte(8'hFF);
      send_byte(8'hEE);            // 18-byte match on position 0, overlapping
      send_byte(8'hFF);            //   itself all the way
      send_byte(8'h00);

      // Random streams; the first has a declared size of zero. Two of them
      // start with a long receiver hold-off.
      stream_idx = 0;
      while (payload_count < RANDOM_ITEMS) begin
         if (stream_idx == 1 || stream_idx == 4) long_hold_req <= 1'b1;
         send_random_stream(stream_idx == 0);
         stream_idx++;
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      // catch any stray transactions after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/lzsd_pkg.sv
rtl/lzsd_ring.sv
rtl/lzsd_copy.sv
rtl/lzss_stream_decompressor_unit.sv
sim/testbench.sv
